@@ rtl/lppd_pkg.sv @@
// Shared types and constants for the length-prefixed path deframer.
// Used by every rtl module of the block; depends on nothing.
`default_nettype none

package lppd_pkg;

    localparam int NUM_LEVELS     = 9;
    localparam int PRIMARY_LEVELS = 5;
    localparam int LEN_BITS       = 16;

    localparam int LEVEL_W = 4;
    localparam int CNT_W   = $clog2(NUM_LEVELS + 1);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] SEP_LEVEL  = 8'h2c; // ','
    localparam logic [7:0] SEP_LENGTH = 8'h3a; // ':'
    localparam logic [7:0] DIGIT_LO   = 8'h30; // '0'
    localparam logic [7:0] DIGIT_HI   = 8'h39; // '9'

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // One queue entry: the result(s) caused by a single input beat.
    typedef struct packed {
        logic               has_res;
        t_kind              kind;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         data;
        logic               value_end;
        logic               has_stat;
        logic               ok;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/lppd_front.sv @@
// Front end: parses path beats and builds at most one queue entry per beat.
// Depends on lppd_pkg.
`default_nettype none

module lppd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_path_byte,
    input  wire logic                 i_end_of_path,
    output logic                      o_push,
    output lppd_pkg::t_cmd            o_cmd
);
    import lppd_pkg::*;

    typedef enum logic [4:0] {
        PH_LEVEL  = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_LIMIT  = 5'b01000,
        PH_FAIL   = 5'b10000
    } t_phase;

    t_phase                 r_phase,  n_phase;
    logic [LEVEL_W-1:0]     r_level,  n_level;
    logic [LEN_BITS-1:0]    r_len,    n_len;
    logic [LEN_BITS-1:0]    r_left,   n_left;
    logic [NUM_LEVELS-1:0]  r_seen,   n_seen;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic                   r_digits, n_digits;

    logic                   digit;
    logic [3:0]             dval;
    logic [7:0]             lvl_sum;
    logic [LEN_BITS+3:0]    len_sum;
    logic [NUM_LEVELS-1:0]  lvl_onehot;
    logic [CNT_W-1:0]       count_inc;
    t_cmd                   cmd;

    assign digit      = (i_path_byte >= DIGIT_LO) && (i_path_byte <= DIGIT_HI);
    assign dval       = digit ? 4'(i_path_byte - DIGIT_LO) : 4'd0;
    assign lvl_sum    = ({4'd0, r_level} << 3) + ({4'd0, r_level} << 1) + {4'd0, dval};
    assign len_sum    = ({4'd0, r_len} << 3) + ({4'd0, r_len} << 1)
                      + {{LEN_BITS{1'b0}}, dval};
    assign lvl_onehot = NUM_LEVELS'(1) << r_level;
    assign count_inc  = r_count + CNT_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_level  = r_level;
        n_len    = r_len;
        n_left   = r_left;
        n_seen   = r_seen;
        n_count  = r_count;
        n_digits = r_digits;

        cmd           = '0;
        cmd.kind      = KIND_VALUE;
        cmd.level     = r_level;

        case (r_phase)
            PH_LEVEL: begin
                if (digit) begin
                    if (lvl_sum >= 8'(NUM_LEVELS)) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_level  = lvl_sum[LEVEL_W-1:0];
                        n_digits = 1'b1;
                    end
                end else if (i_path_byte == SEP_LEVEL && r_digits
                             && !(|(r_seen & lvl_onehot))) begin
                    n_seen   = r_seen | lvl_onehot;
                    n_digits = 1'b0;
                    n_len    = '0;
                    n_phase  = PH_LENGTH;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_LENGTH: begin
                if (digit) begin
                    if (|len_sum[LEN_BITS+3:LEN_BITS]) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_len    = len_sum[LEN_BITS-1:0];
                        n_digits = 1'b1;
                    end
                end else if (i_path_byte == SEP_LENGTH && r_digits) begin
                    if (r_len == '0) begin
                        if (r_level >= LEVEL_W'(PRIMARY_LEVELS)) begin
                            n_phase = PH_FAIL;
                        end else begin
                            // empty primary component: marker, then close it
                            cmd.has_res = 1'b1;
                            cmd.kind    = KIND_MARK;
                            n_count     = count_inc;
                            n_level     = '0;
                            n_len       = '0;
                            n_digits    = 1'b0;
                            n_phase     = (count_inc >= CNT_W'(NUM_LEVELS)) ? PH_LIMIT
                                                                             : PH_LEVEL;
                        end
                    end else begin
                        n_left  = r_len;
                        n_phase = PH_VALUE;
                    end
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_VALUE: begin
                cmd.has_res   = 1'b1;
                cmd.data      = i_path_byte;
                cmd.value_end = (r_left == LEN_BITS'(1));
                n_left        = r_left - LEN_BITS'(1);
                if (r_left == LEN_BITS'(1)) begin
                    n_count  = count_inc;
                    n_level  = '0;
                    n_len    = '0;
                    n_digits = 1'b0;
                    n_phase  = (count_inc >= CNT_W'(NUM_LEVELS)) ? PH_LIMIT : PH_LEVEL;
                end
            end
            PH_LIMIT: begin
                n_phase = PH_FAIL;
            end
            PH_FAIL: begin
                n_phase = PH_FAIL;
            end
            default: begin
                n_phase = PH_FAIL;
            end
        endcase

        if (i_end_of_path) begin
            cmd.has_stat = 1'b1;
            cmd.ok       = (n_phase == PH_LEVEL && !n_digits && n_count != '0)
                         || n_phase == PH_LIMIT;
            // start afresh for the next path
            n_phase  = PH_LEVEL;
            n_level  = '0;
            n_len    = '0;
            n_left   = '0;
            n_seen   = '0;
            n_count  = '0;
            n_digits = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEVEL;
            r_level  <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_seen   <= '0;
            r_count  <= '0;
            r_digits <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_len    <= n_len;
            r_left   <= n_left;
            r_seen   <= n_seen;
            r_count  <= n_count;
            r_digits <= n_digits;
        end
    end

    assign o_push = i_accept && (cmd.has_res || cmd.has_stat);
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

@@ rtl/lppd_queue.sv @@
// Short register queue between the parser and the result emitter.
// Depends on lppd_pkg.
`default_nettype none

module lppd_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire lppd_pkg::t_cmd i_cmd,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lppd_pkg::t_cmd o_cmd
);
    import lppd_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = i_push ? QPTR_W'(r_wr + QPTR_W'(1)) : r_wr;
        n_rd  = do_pop ? QPTR_W'(r_rd + QPTR_W'(1)) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

endmodule

`default_nettype wire

@@ rtl/lppd_back.sv @@
// Back end: unpacks queue entries into result beats on a registered output.
// Depends on lppd_pkg.
`default_nettype none

module lppd_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire lppd_pkg::t_cmd i_q_cmd,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_level,
    output logic [7:0]      o_data,
    output logic            o_value_end,
    output logic            o_ok,
    output logic            o_last
);
    import lppd_pkg::*;

    logic               r_valid;
    logic               r_half, n_half;
    t_kind              r_kind, n_kind;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [7:0]         r_data, n_data;
    logic               r_vend, n_vend;
    logic               r_ok, n_ok;
    logic               r_last, n_last;
    logic               load;
    logic               take_res;

    assign load     = i_q_valid && (!r_valid || !i_stall);
    // r_half: the primary result of the head entry has gone, its status remains
    assign take_res = i_q_cmd.has_res && !r_half;

    always_comb begin
        n_half  = r_half;
        n_kind  = r_kind;
        n_level = r_level;
        n_data  = r_data;
        n_vend  = r_vend;
        n_ok    = r_ok;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            if (take_res) begin
                n_kind  = i_q_cmd.kind;
                n_level = i_q_cmd.level;
                n_data  = i_q_cmd.data;
                n_vend  = i_q_cmd.value_end;
                n_ok    = 1'b0;
                n_last  = 1'b0;
                n_half  = i_q_cmd.has_stat;
                o_pop   = !i_q_cmd.has_stat;
            end else begin
                n_kind  = KIND_STATUS;
                n_level = '0;
                n_data  = '0;
                n_vend  = 1'b0;
                n_ok    = i_q_cmd.ok;
                n_last  = 1'b1;
                n_half  = 1'b0;
                o_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            r_half <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_level <= n_level;
        r_data  <= n_data;
        r_vend  <= n_vend;
        r_ok    <= n_ok;
        r_last  <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_level     = r_level;
    assign o_data      = r_data;
    assign o_value_end = r_vend;
    assign o_ok        = r_ok;
    assign o_last      = r_last;

endmodule

`default_nettype wire

@@ rtl/length_prefixed_path_deframer.sv @@
// Length-prefixed path deframer, top level: parser, four-entry queue, emitter.
// Each result is queued as its byte is taken, then moved to the output register.
// Throughput: one path byte per cycle while the queue is not full; a final byte
// that carries a value byte or a marker yields two results, sent as two beats.
// Synchronous active-low reset: parser expects level digits, queue and output empty.
// Depends on lppd_pkg, lppd_front, lppd_queue and lppd_back.
`default_nettype none

module length_prefixed_path_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_path_byte,
    input  wire logic       i_end_of_path,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_level,
    output logic [7:0]      o_data,
    output logic            o_value_end,
    output logic            o_ok,
    output logic            o_last
);
    import lppd_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    lppd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_path_byte   (i_path_byte),
        .i_end_of_path (i_end_of_path),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lppd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lppd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_level     (o_level),
        .o_data      (o_data),
        .o_value_end (o_value_end),
        .o_ok        (o_ok),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

@@ test/length_prefixed_path_deframer_tb.sv @@
// Self-checking testbench for length_prefixed_path_deframer: directed and random paths,
// bursty sender, patterned receiver stalls, in-bench prediction of every result.
// Depends on lppd_pkg and the deframer rtl.
module length_prefixed_path_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lppd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1550;

    typedef enum int {
        PH_LEVEL,
        PH_LENGTH,
        PH_VALUE,
        PH_LIMIT,
        PH_FAIL
    } t_parse_phase;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct {
        logic [7:0] ch;
        logic       eop;
        logic       drain;
    } t_beat;

    typedef struct {
        t_kind      kind;
        logic [3:0] level;
        logic [7:0] data;
        logic       value_end;
        logic       ok;
        logic       last;
    } t_deframed;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       drv_valid   = 1'b0;
    logic [7:0] path_byte   = 8'h00;
    logic       path_end    = 1'b0;
    logic       rcv_stall   = 1'b0;
    logic       dut_stall;
    logic       out_valid;
    logic [1:0] out_kind;
    logic [3:0] out_level;
    logic [7:0] out_data;
    logic       out_value_end;
    logic       out_ok;
    logic       out_last;

    t_beat      path_beats[$];
    t_deframed  due_results[$];
    logic [7:0] path_buf[$];

    // Predictor state
    t_parse_phase          phase_q;
    int                    level_acc;
    int                    length_acc;
    int                    value_left;
    logic [NUM_LEVELS-1:0] levels_used;
    int                    parts_done;
    logic                  have_digits;

    int          items_sent  = 0;
    int          fail_count  = 0;
    int          cycles      = 0;
    logic        took_beat   = 1'b0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;

    length_prefixed_path_deframer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (drv_valid),
        .o_stall       (dut_stall),
        .i_path_byte   (path_byte),
        .i_end_of_path (path_end),
        .o_valid       (out_valid),
        .i_stall       (rcv_stall),
        .o_kind        (out_kind),
        .o_level       (out_level),
        .o_data        (out_data),
        .o_value_end   (out_value_end),
        .o_ok          (out_ok),
        .o_last        (out_last)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic clear_parser();
        phase_q     = PH_LEVEL;
        level_acc   = 0;
        length_acc  = 0;
        value_left  = 0;
        levels_used = '0;
        parts_done  = 0;
        have_digits = 1'b0;
    endtask

    task automatic close_component();
        parts_done  = parts_done + 1;
        level_acc   = 0;
        length_acc  = 0;
        have_digits = 1'b0;
        phase_q     = (parts_done >= NUM_LEVELS) ? PH_LIMIT : PH_LEVEL;
    endtask

    function automatic t_deframed make_result(t_kind k, int lvl, logic [7:0] d,
                                              logic vend, logic good, logic fin);
        t_deframed r;
        r.kind      = k;
        r.level     = 4'(lvl);
        r.data      = d;
        r.value_end = vend;
        r.ok        = good;
        r.last      = fin;
        return r;
    endfunction

    // Advance the parser by one byte and queue the results it causes.
    task automatic deframe_byte(input logic [7:0] b, input logic eop);
        logic is_digit;
        logic good;
        int   d;
        int   v;
        is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
        d        = is_digit ? int'(b - DIGIT_LO) : 0;
        case (phase_q)
            PH_LEVEL: begin
                if (is_digit) begin
                    v = level_acc * 10 + d;
                    if (v >= NUM_LEVELS) begin
                        phase_q = PH_FAIL;
                    end else begin
                        level_acc   = v;
                        have_digits = 1'b1;
                    end
                end else if (b == SEP_LEVEL && have_digits && !levels_used[level_acc]) begin
                    levels_used[level_acc] = 1'b1;
                    have_digits = 1'b0;
                    length_acc  = 0;
                    phase_q     = PH_LENGTH;
                end else begin
                    phase_q = PH_FAIL;
                end
            end
            PH_LENGTH: begin
                if (is_digit) begin
                    v = length_acc * 10 + d;
                    if (v > (1 << LEN_BITS) - 1) begin
                        phase_q = PH_FAIL;
                    end else begin
                        length_acc  = v;
                        have_digits = 1'b1;
                    end
                end else if (b == SEP_LENGTH && have_digits) begin
                    if (length_acc == 0) begin
                        if (level_acc >= PRIMARY_LEVELS) begin
                            phase_q = PH_FAIL;
                        end else begin
                            due_results.push_back(make_result(KIND_MARK, level_acc, 8'h00,
                                                              1'b0, 1'b0, 1'b0));
                            close_component();
                        end
                    end else begin
                        value_left = length_acc;
                        phase_q    = PH_VALUE;
                    end
                end else begin
                    phase_q = PH_FAIL;
                end
            end
            PH_VALUE: begin
                due_results.push_back(make_result(KIND_VALUE, level_acc, b,
                                                  value_left == 1, 1'b0, 1'b0));
                value_left = value_left - 1;
                if (value_left == 0)
                    close_component();
            end
            default: begin
                phase_q = PH_FAIL;
            end
        endcase
        if (eop) begin
            good = (phase_q == PH_LEVEL && !have_digits && parts_done > 0) ||
                   (phase_q == PH_LIMIT);
            due_results.push_back(make_result(KIND_STATUS, 0, 8'h00, 1'b0, good, 1'b1));
            clear_parser();
        end
    endtask

    // Take input beats into the predictor, then check output beats.
    always @(posedge clk) begin
        t_deframed want;
        took_beat = rst_n && drv_valid && !dut_stall;
        if (took_beat)
            deframe_byte(path_byte, path_end);
        if (rst_n && out_valid && !rcv_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d level %0d data %0h",
                       out_kind, out_level, out_data);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (out_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_kind);
                    fail_count++;
                end
                if (out_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, out_level);
                    fail_count++;
                end
                if (out_data !== want.data) begin
                    $error("data: expected %0h, got %0h", want.data, out_data);
                    fail_count++;
                end
                if (out_value_end !== want.value_end) begin
                    $error("value_end: expected %0b, got %0b", want.value_end, out_value_end);
                    fail_count++;
                end
                if (out_ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, out_ok);
                    fail_count++;
                end
                if (out_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_last);
                    fail_count++;
                end
            end
        end
    end

    // Sender: bursts and gaps; a beat marked drain waits for all results to land.
    always @(negedge clk) begin
        logic  next_valid;
        t_beat nb;
        if (rst_n && !(drv_valid && !took_beat)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (path_beats.size() > 0 &&
                         !(path_beats[0].drain && due_results.size() != 0)) begin
                nb         = path_beats.pop_front();
                next_valid = 1'b1;
                path_byte <= nb.ch;
                path_end  <= nb.eop;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
            drv_valid <= next_valid;
        end
    end

    // Receiver: stall pattern changes mode every so often.
    always @(negedge clk) begin
        logic next_stall;
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  next_stall = 1'b0;
            STALL_LIGHT: next_stall = ($urandom_range(0, 2) == 0);
            STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
            default:     next_stall = ((cycles % 5) < 2);
        endcase
        rcv_stall <= next_stall;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("length_prefixed_path_deframer_tb NOT OK");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        path_buf.push_back(b);
    endtask

    task automatic add_num(input int v, input int zeros);
        int p;
        p = 1;
        repeat (zeros) path_buf.push_back(DIGIT_LO);
        while (p * 10 <= v) p = p * 10;
        while (p > 0) begin
            path_buf.push_back(DIGIT_LO + 8'((v / p) % 10));
            p = p / 10;
        end
    endtask

    task automatic add_head(input int lvl, input int len);
        add_num(lvl, 0);
        add_byte(SEP_LEVEL);
        add_num(len, 0);
        add_byte(SEP_LENGTH);
    endtask

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return DIGIT_LO + 8'($urandom_range(0, 9));
        else if (r < 5)
            return SEP_LEVEL;
        else if (r < 7)
            return SEP_LENGTH;
        return 8'($urandom_range(1, 255));
    endfunction

    // Queue the assembled path as beats; the last one carries end of path.
    task automatic send_path(input logic drain);
        t_beat nb;
        foreach (path_buf[i]) begin
            nb.ch    = path_buf[i];
            nb.eop   = (i == path_buf.size() - 1);
            nb.drain = drain && (i == 0);
            path_beats.push_back(nb);
        end
        items_sent += path_buf.size();
        path_buf.delete();
    endtask

    task automatic gen_path();
        int   order[NUM_LEVELS];
        int   n;
        int   r;
        int   lvl;
        int   len;
        int   j;
        int   t;
        logic stop;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(pick_noise());
            return;
        end
        foreach (order[i]) order[i] = i;
        for (int i = NUM_LEVELS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        r = $urandom_range(0, 9);
        n = (r < 6) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 8) : NUM_LEVELS;
        stop = 1'b0;
        for (int i = 0; i < n && !stop; i++) begin
            lvl = order[i];
            r   = $urandom_range(0, 99);
            if (i > 0 && r < 4)
                lvl = order[0];
            else if (r < 6)
                lvl = $urandom_range(NUM_LEVELS, 15);
            add_num(lvl, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            add_byte(SEP_LEVEL);
            r = $urandom_range(0, 99);
            if (r < 2) begin
                // huge length: either at the limit and cut short, or past it
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    add_num((1 << LEN_BITS) - 1, 0);
                    add_byte(SEP_LENGTH);
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(1, 255)));
                end else begin
                    add_num((r == 1) ? (1 << LEN_BITS) : $urandom_range(65537, 999999), 0);
                end
                stop = 1'b1;
            end else begin
                if (r < 17)
                    len = 0;
                else if (r < 92)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(7, 40);
                add_num(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
                add_byte(SEP_LENGTH);
                repeat (len) add_byte(8'($urandom_range(1, 255)));
            end
        end
        if (n == NUM_LEVELS && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) add_byte(pick_noise());
        r = $urandom_range(0, 99);
        if (r < 8) begin
            t = $urandom_range(1, path_buf.size());
            while (path_buf.size() > t) void'(path_buf.pop_back());
        end else if (r < 16) begin
            path_buf[$urandom_range(0, path_buf.size() - 1)] = pick_noise();
        end
    endtask

    initial begin
        int paths;
        clear_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed paths
        add_head(0, 1);
        add_byte(8'hff);
        send_path(1'b0);
        add_head(PRIMARY_LEVELS - 1, 0);
        add_head(NUM_LEVELS - 1, 1);
        add_byte(8'h01);
        send_path(1'b0);
        add_num(NUM_LEVELS, 0);
        send_path(1'b0);
        add_head(PRIMARY_LEVELS, 0);
        send_path(1'b0);
        add_num(0, 0);
        add_byte(SEP_LEVEL);
        add_num(6, 0);
        send_path(1'b0);
        add_byte(SEP_LEVEL);
        send_path(1'b0);
        add_num(0, 0);
        add_byte(SEP_LEVEL);
        add_num(1 << LEN_BITS, 0);
        send_path(1'b0);

        // Random paths; every so often hold off until the block has drained
        paths = 0;
        while (items_sent < ITEM_TARGET) begin
            gen_path();
            send_path(paths % 60 == 0);
            paths++;
        end

        while (path_beats.size() != 0 || drv_valid) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0) begin
            $display("length_prefixed_path_deframer_tb OK");
        end else begin
            $display("length_prefixed_path_deframer_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ length_prefixed_path_deframer.f @@
rtl/lppd_pkg.sv
rtl/lppd_front.sv
rtl/lppd_queue.sv
rtl/lppd_back.sv
rtl/length_prefixed_path_deframer.sv
test/length_prefixed_path_deframer_tb.sv
